// ===== design/tspc_pkg.sv =====
// Shared constants for the tile and sprite pixel compositor.
// No dependencies; tspc_if, the top level and the checker refer to it by scoped names.
package tspc_pkg;

	localparam int OP_W   = 2;
	localparam int ADDR_W = 14;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int TILE_DEPTH = 16384;

	// item operations
	localparam logic [OP_W-1:0] OP_TILE_WR = 2'd0;
	localparam logic [OP_W-1:0] OP_SPR_WR  = 2'd1;
	localparam logic [OP_W-1:0] OP_RENDER  = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LCD_CONTROL = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCROLL_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_PALETTE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_OBJ_PALETTE = 3'd7;

	localparam logic [7:0]  LCD_CONTROL_RST = 8'd145;
	localparam logic [7:0]  BG_PALETTE_RST  = 8'd252;

	// layer select codes
	localparam logic [1:0] SEL_BG   = 2'd0;
	localparam logic [1:0] SEL_HIGH = 2'd1;
	localparam logic [1:0] SEL_LOW  = 2'd2;
	localparam logic [1:0] SEL_NONE = 2'd3;

	typedef struct packed {
		logic       present;
		logic [1:0] raw;
		logic [2:0] pal;
	} pix_t;

endpackage

// ===== design/tspc_if.sv =====
// Valid/ready channel interfaces for item and pixel beats.
// Depends on tspc_pkg for field widths.
interface tspc_item_if;
	logic                          valid;
	logic                          ready;
	logic [tspc_pkg::OP_W-1:0]     op;
	logic [tspc_pkg::ADDR_W-1:0]   mem_addr;
	logic [tspc_pkg::BYTE_W-1:0]   write_data;
	logic [7:0]                    line_num;
	logic [7:0]                    pixel_col;
	modport source (output valid, op, mem_addr, write_data, line_num, pixel_col, input ready);
	modport sink   (input valid, op, mem_addr, write_data, line_num, pixel_col, output ready);
endinterface

interface tspc_pix_if;
	logic       valid;
	logic       ready;
	logic       from_sprite;
	logic [2:0] palette_id;
	logic [1:0] raw_color;
	logic [1:0] shade;
	modport source (output valid, from_sprite, palette_id, raw_color, shade, input ready);
	modport sink   (input valid, from_sprite, palette_id, raw_color, shade, output ready);
endinterface

// ===== design/tile_sprite_pixel_compositor_top.sv =====
// Tile/sprite pixel compositor: one render beat yields one pixel beat.
// A render beat runs the map, attribute, tile low and tile high reads, then the output
// load; with sprites on, each sprite entry is read and checked, and each entry that
// covers the pixel adds its own tile low and tile high reads. Write beats leave the block
// idle and ready for the next beat; a stalled pixel holds the block. Reset (arst_n low,
// asynchronous) restores register defaults and idles.
module tile_sprite_pixel_compositor_top #(
	parameter int NUM_SPRITES  = 40,
	parameter int WINDOW_LIMIT = 168
) (
	input  logic                             clk,
	input  logic                             arst_n,
	tspc_item_if.sink                        item_in,
	tspc_pix_if.source                       pix_out,
	input  logic                             cfg_we,
	input  logic [tspc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tspc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	localparam int SI_W = (NUM_SPRITES > 1) ? $clog2(NUM_SPRITES) : 1;
	localparam logic [SI_W-1:0] LAST_SPR = SI_W'(NUM_SPRITES - 1);
	localparam logic [tspc_pkg::ADDR_W-1:0] SPR_BYTES = tspc_pkg::ADDR_W'(NUM_SPRITES * 4);

	// sequencer states
	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_MAP    = 4'd1;
	localparam logic [3:0] ST_ATTR   = 4'd2;
	localparam logic [3:0] ST_BGADDR = 4'd3;
	localparam logic [3:0] ST_BGLO   = 4'd4;
	localparam logic [3:0] ST_BGHI   = 4'd5;
	localparam logic [3:0] ST_BGBIT  = 4'd6;
	localparam logic [3:0] ST_SREAD  = 4'd7;
	localparam logic [3:0] ST_SCHK   = 4'd8;
	localparam logic [3:0] ST_TLO    = 4'd9;
	localparam logic [3:0] ST_THI    = 4'd10;
	localparam logic [3:0] ST_TBIT   = 4'd11;
	localparam logic [3:0] ST_DONE   = 4'd12;

	// configuration registers
	logic [7:0]  lcd_q, scx_q, scy_q, wx_q, wy_q, bgp_q;
	logic        cmode_q;
	logic [15:0] obp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcd_q   <= tspc_pkg::LCD_CONTROL_RST;
			scx_q   <= '0;
			scy_q   <= '0;
			wx_q    <= '0;
			wy_q    <= '0;
			cmode_q <= 1'b0;
			bgp_q   <= tspc_pkg::BG_PALETTE_RST;
			obp_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tspc_pkg::CFG_LCD_CONTROL: lcd_q   <= cfg_wdata[7:0];
				tspc_pkg::CFG_SCROLL_X:    scx_q   <= cfg_wdata[7:0];
				tspc_pkg::CFG_SCROLL_Y:    scy_q   <= cfg_wdata[7:0];
				tspc_pkg::CFG_WINDOW_X:    wx_q    <= cfg_wdata[7:0];
				tspc_pkg::CFG_WINDOW_Y:    wy_q    <= cfg_wdata[7:0];
				tspc_pkg::CFG_COLOR_MODE:  cmode_q <= cfg_wdata[0];
				tspc_pkg::CFG_BG_PALETTE:  bgp_q   <= cfg_wdata[7:0];
				tspc_pkg::CFG_OBJ_PALETTE: obp_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic [3:0] state_q;
	logic       in_acc;
	assign item_in.ready = (state_q == ST_IDLE);
	assign in_acc = item_in.valid && item_in.ready;

	// tile memory: writes come straight from the beat, reads from the sequencer
	logic        tram_we;
	logic [13:0] tram_raddr;
	logic [7:0]  tram_rdata;
	logic [13:0] addr_q;
	logic [12:0] map_q;

	assign tram_we = in_acc && (item_in.op == tspc_pkg::OP_TILE_WR);

	always_comb begin
		case (state_q)
			ST_MAP:  tram_raddr = {1'b0, map_q};
			ST_ATTR: tram_raddr = {1'b1, map_q};
			ST_BGHI, ST_THI: tram_raddr = {addr_q[13:1], 1'b1};
			default: tram_raddr = addr_q;
		endcase
	end

	tspc_ram #(.WIDTH(8), .DEPTH(tspc_pkg::TILE_DEPTH)) u_tile_ram (
		.clk   (clk),
		.we    (tram_we),
		.waddr (item_in.mem_addr),
		.wdata (item_in.write_data),
		.raddr (tram_raddr),
		.rdata (tram_rdata)
	);

	// sprite table: one RAM per byte lane (y, x, tile, attributes)
	logic [SI_W-1:0] idx_q;
	logic [7:0]      spr_rd [4];
	logic            spr_wr_ok;
	assign spr_wr_ok = in_acc && (item_in.op == tspc_pkg::OP_SPR_WR)
		&& (item_in.mem_addr < SPR_BYTES);

	for (genvar g = 0; g < 4; g++) begin : g_spr_lane
		tspc_ram #(.WIDTH(8), .DEPTH(NUM_SPRITES)) u_spr_ram (
			.clk   (clk),
			.we    (spr_wr_ok && (item_in.mem_addr[1:0] == 2'(g))),
			.waddr (item_in.mem_addr[SI_W+1:2]),
			.wdata (item_in.write_data),
			.raddr (idx_q),
			.rdata (spr_rd[g])
		);
	end

	// pixel coordinates and map position, fixed at the render beat
	logic [7:0] line_q, col_q;
	logic [2:0] px_q, py_q, bit_q;
	logic [7:0] sx, sy, wline;
	logic [9:0] wcol;
	logic       win_on;

	assign sx    = item_in.pixel_col + scx_q;
	assign sy    = item_in.line_num + scy_q;
	assign wline = item_in.line_num - wy_q;
	assign wcol  = {2'b00, item_in.pixel_col} + 10'd7 - {2'b00, wx_q};
	// window only where its column lands in 0..255 (left edge clipped)
	assign win_on = lcd_q[5] && (item_in.line_num >= wy_q)
		&& ({1'b0, item_in.pixel_col} < 9'(WINDOW_LIMIT)) && (wcol[9:8] == 2'b00);

	// shared tile-bit picker: hi byte on the read port, lo byte held
	logic [7:0] lo_q, id_q;
	logic [1:0] pix_bit;
	assign pix_bit = {tram_rdata[bit_q], lo_q[bit_q]};

	// background attribute decode
	logic [7:0] bg_attr;
	logic [8:0] bg_tile;
	assign bg_attr = cmode_q ? tram_rdata : 8'd0;
	assign bg_tile = {~lcd_q[4] & ~id_q[7], id_q};

	// sprite entry test
	logic [9:0] srow;
	logic [7:0] sdx, stile;
	logic       tall, shit;
	logic [2:0] spy;
	assign tall  = lcd_q[2];
	assign srow  = {2'b00, line_q} + 10'd16 - {2'b00, spr_rd[0]};
	assign sdx   = col_q + 8'd8 - spr_rd[1];
	assign shit  = (srow[9:4] == 6'd0) && (tall || !srow[3]) && (sdx[7:3] == 5'd0);
	assign stile = tall ? {spr_rd[2][7:1], srow[3] ^ spr_rd[3][6]} : spr_rd[2];
	assign spy   = spr_rd[3][6] ? ~srow[2:0] : srow[2:0];

	tspc_pkg::pix_t bg_q, shi_q, slo_q, shi_n, slo_n;
	logic           bg_high_q, sbelow_q;
	logic [2:0]     spal_q;

	// first-hit update per priority class
	always_comb begin
		shi_n = shi_q;
		slo_n = slo_q;
		if (pix_bit != 2'd0) begin
			if (sbelow_q && !slo_q.present) begin
				slo_n = '{present: 1'b1, raw: pix_bit, pal: spal_q};
			end
			if (!sbelow_q && !shi_q.present) begin
				shi_n = '{present: 1'b1, raw: pix_bit, pal: spal_q};
			end
		end
	end

	// layer selection
	logic [1:0]     sel;
	tspc_pkg::pix_t pick;
	logic [1:0]     shade;
	always_comb begin
		if (lcd_q[0]) begin
			sel = tspc_pkg::SEL_LOW;
			if (!bg_high_q && (bg_q.raw != 2'd0 || !slo_q.present)) sel = tspc_pkg::SEL_BG;
			if (shi_q.present) sel = tspc_pkg::SEL_HIGH;
			if (bg_high_q && (bg_q.raw != 2'd0 || (!shi_q.present && !slo_q.present)))
				sel = tspc_pkg::SEL_BG;
			if (sel == tspc_pkg::SEL_LOW && !slo_q.present) sel = tspc_pkg::SEL_BG;
		end else begin
			sel = tspc_pkg::SEL_NONE;
			if (bg_q.raw != 2'd0) sel = tspc_pkg::SEL_BG;
			if (slo_q.present) sel = tspc_pkg::SEL_LOW;
			if (shi_q.present) sel = tspc_pkg::SEL_HIGH;
			if (sel == tspc_pkg::SEL_NONE) sel = tspc_pkg::SEL_BG;
		end
		case (sel)
			tspc_pkg::SEL_HIGH: pick = shi_q;
			tspc_pkg::SEL_LOW:  pick = slo_q;
			default:            pick = bg_q;
		endcase
		if (cmode_q) shade = pick.raw;
		else if (sel == tspc_pkg::SEL_BG) shade = bgp_q[{pick.raw, 1'b0} +: 2];
		else shade = obp_q[{pick.pal[0], pick.raw, 1'b0} +: 2];
	end

	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!pix_out.valid || pix_out.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_acc && item_in.op == tspc_pkg::OP_RENDER) state_q <= ST_MAP;
				ST_MAP:    state_q <= ST_ATTR;
				ST_ATTR:   state_q <= ST_BGADDR;
				ST_BGADDR: state_q <= ST_BGLO;
				ST_BGLO:   state_q <= ST_BGHI;
				ST_BGHI:   state_q <= ST_BGBIT;
				ST_BGBIT: begin
					idx_q   <= '0;
					state_q <= lcd_q[1] ? ST_SREAD : ST_DONE;
				end
				ST_SREAD: state_q <= ST_SCHK;
				ST_SCHK: begin
					if (shit) state_q <= ST_TLO;
					else if (idx_q == LAST_SPR) state_q <= ST_DONE;
					else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SREAD;
					end
				end
				ST_TLO: state_q <= ST_THI;
				ST_THI: state_q <= ST_TBIT;
				ST_TBIT: begin
					// stop once both classes have their winner or the last entry is done
					if ((shi_n.present && slo_n.present) || idx_q == LAST_SPR) state_q <= ST_DONE;
					else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SREAD;
					end
				end
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			line_q <= item_in.line_num;
			col_q  <= item_in.pixel_col;
			if (win_on) begin
				map_q <= {2'b11, lcd_q[6], wline[7:3], wcol[7:3]};
				px_q  <= wcol[2:0];
				py_q  <= wline[2:0];
			end else begin
				map_q <= {2'b11, lcd_q[3], sy[7:3], sx[7:3]};
				px_q  <= sx[2:0];
				py_q  <= sy[2:0];
			end
		end
		case (state_q)
			ST_ATTR: id_q <= tram_rdata;
			ST_BGADDR: begin
				addr_q    <= {bg_attr[3], bg_tile, bg_attr[6] ? ~py_q : py_q, 1'b0};
				bit_q     <= bg_attr[5] ? px_q : ~px_q;
				bg_q.pal  <= bg_attr[2:0];
				bg_high_q <= bg_attr[7];
			end
			ST_BGHI, ST_THI: lo_q <= tram_rdata;
			ST_BGBIT: begin
				bg_q.present <= 1'b1;
				bg_q.raw     <= pix_bit;
				shi_q        <= '0;
				slo_q        <= '0;
			end
			ST_SCHK: begin
				addr_q   <= {cmode_q & spr_rd[3][3], 1'b0, stile, spy, 1'b0};
				bit_q    <= spr_rd[3][5] ? sdx[2:0] : ~sdx[2:0];
				spal_q   <= cmode_q ? spr_rd[3][2:0] : {2'b00, spr_rd[3][4]};
				sbelow_q <= spr_rd[3][7];
			end
			ST_TBIT: begin
				shi_q <= shi_n;
				slo_q <= slo_n;
			end
			default: ;
		endcase
	end

	// output register: holds a finished pixel until taken
	logic       from_spr_q;
	logic [2:0] pal_q;
	logic [1:0] raw_q, shade_q;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			from_spr_q <= (sel != tspc_pkg::SEL_BG);
			pal_q      <= pick.pal;
			raw_q      <= pick.raw;
			shade_q    <= shade;
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.from_sprite = from_spr_q;
	assign pix_out.palette_id  = pal_q;
	assign pix_out.raw_color   = raw_q;
	assign pix_out.shade       = shade_q;
endmodule

// ===== design/tspc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tspc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== design/tspc_checker.sv =====
// Port-level checks for the compositor, bound onto the top level.
// Depends on tspc_pkg for operation codes.
module tspc_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [tspc_pkg::OP_W-1:0]   in_op,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [7:0]                  out_bits
);
	// hold a stalled pixel beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_bits))
		else $error("stalled pixel beat changed");

	// a render beat occupies the block
	a_render_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == tspc_pkg::OP_RENDER |=> !in_ready)
		else $error("ready stayed high after render beat");

	// a non-render beat makes no pixel
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op != tspc_pkg::OP_RENDER && !out_valid |=> !out_valid)
		else $error("pixel without render beat");

	// a render beat never yields its pixel in the next cycle
	a_render_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_op == tspc_pkg::OP_RENDER && !out_valid |=> !out_valid)
		else $error("pixel too early");
endmodule

bind tile_sprite_pixel_compositor_top tspc_checker u_tspc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item_in.valid),
	.in_ready  (item_in.ready),
	.in_op     (item_in.op),
	.out_valid (pix_out.valid),
	.out_ready (pix_out.ready),
	.out_bits  ({pix_out.from_sprite, pix_out.palette_id, pix_out.raw_color, pix_out.shade})
);
